// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that is also checked during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ilu_pkg.sv -----
package ilu_pkg;

    // request kinds
    localparam logic [2:0] KIND_ADD_FRONT = 3'd0;
    localparam logic [2:0] KIND_ADD_REAR  = 3'd1;
    localparam logic [2:0] KIND_ADD_AT    = 3'd2;
    localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [2:0] KIND_DEL_REAR  = 3'd4;
    localparam logic [2:0] KIND_DEL_AT    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    // slot index width, enough for the largest list supported
    localparam int IDX_W = 8;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
    } ilu_ctrl_t;

endpackage

// ----- hdl/ilu_cell.sv -----
module ilu_cell #(
    parameter int WIDTH = 32,
    parameter int INDEX = 0
) (
    input  logic                aclk,
    input  ilu_pkg::ilu_ctrl_t  ctrl,
    input  logic [WIDTH-1:0]    ins_value,
    input  logic [WIDTH-1:0]    left_data,
    input  logic [WIDTH-1:0]    right_data,
    output logic [WIDTH-1:0]    data
);
    import ilu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // shift towards the rear on insert, towards the front on delete
    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (MY_IDX > ctrl.idx) begin
                    data_next = left_data;
                end else if (MY_IDX == ctrl.idx) begin
                    data_next = ins_value;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= ctrl.idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- hdl/indexed_ordered_list_unit.sv -----
// Channel | Direction | tdata (low bit up)                          | tuser
// s_      | in        | position[4:0], value[36:5], zero pad to 40  | kind[2:0]
// m_      | out       | removed_value[31:0], count_now[36:32],      | status[1:0]
//         |           | is_empty[37], zero pad to 40                |
//
// One item per cycle unless the result side stalls: every operation is decoded and applied
// to the cell row in the cycle it is accepted, and its result is registered for the next.
// The shift of the cells from the addressed slot onward by one place is done in parallel, one step per item.
// A new item is taken whenever the result register is empty or being drained.
// Synchronous active-low reset empties the list; slot contents are not cleared.
module indexed_ordered_list_unit #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[4:0], value[36:5], pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // removed_value[31:0], count_now[36:32], is_empty[37], pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import ilu_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ((CW > 5) ? CW : 5) + 1;

    logic [4:0]            s_pos;
    logic [31:0]           s_value;
    logic                  s_acc;
    logic [WORD_WIDTH-1:0] ins_word;
    logic [EW-1:0]         pos_e;
    logic [EW-1:0]         cnt_e;
    logic [EW-1:0]         cap_e;

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [31:0]           removed_reg;
    logic [1:0]            status_reg;
    logic [4:0]            cnt_out_reg;
    logic                  empty_reg;

    ilu_ctrl_t             ctrl;
    logic                  do_del;
    logic [1:0]            status;
    logic [WORD_WIDTH-1:0] rd_word;
    logic [WORD_WIDTH-1:0] cell_data [CAPACITY];

    assign s_pos    = s_tdata[4:0];
    assign s_value  = s_tdata[36:5];
    assign s_tready = !m_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign ins_word = WORD_WIDTH'(s_value);
    assign pos_e    = EW'(s_pos);
    assign cnt_e    = EW'(count_reg);
    assign cap_e    = EW'(CAPACITY);

    // request decode: status, cell operation and slot index
    always_comb begin
        status  = ST_OK;
        ctrl.op = CELL_HOLD;
        ctrl.idx = '0;
        do_del  = 1'b0;
        case (s_tuser)
            KIND_ADD_FRONT, KIND_ADD_REAR, KIND_ADD_AT: begin
                if (s_tuser == KIND_ADD_AT && (pos_e == '0 || pos_e > cnt_e + EW'(1))) begin
                    status = ST_RANGE;
                end else if (cnt_e >= cap_e) begin
                    status = ST_FULL;
                end else begin
                    ctrl.op = CELL_INS;
                    if (s_tuser == KIND_ADD_FRONT) begin
                        ctrl.idx = '0;
                    end else if (s_tuser == KIND_ADD_REAR) begin
                        ctrl.idx = IDX_W'(count_reg);
                    end else begin
                        ctrl.idx = IDX_W'(s_pos - 5'd1);
                    end
                end
            end
            KIND_DEL_FRONT, KIND_DEL_REAR: begin
                if (count_reg == '0) begin
                    status = ST_UNDER;
                end else begin
                    ctrl.op = CELL_DEL;
                    do_del  = 1'b1;
                    if (s_tuser == KIND_DEL_FRONT) begin
                        ctrl.idx = '0;
                    end else begin
                        ctrl.idx = IDX_W'(count_reg - CW'(1));
                    end
                end
            end
            KIND_DEL_AT: begin
                if (pos_e == '0 || pos_e > cnt_e) begin
                    status = ST_RANGE;
                end else begin
                    ctrl.op  = CELL_DEL;
                    do_del   = 1'b1;
                    ctrl.idx = IDX_W'(s_pos - 5'd1);
                end
            end
            default: begin
                status = ST_RANGE;
            end
        endcase
        if (!s_acc) begin
            ctrl.op = CELL_HOLD;
        end
    end

    // row of slot cells, each fed by its two neighbours
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_d;
        logic [WORD_WIDTH-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        ilu_cell #(
            .WIDTH (WORD_WIDTH),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .ins_value  (ins_word),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i])
        );
    end

    // word leaving the list on a delete
    assign rd_word = cell_data[ctrl.idx[AW-1:0]];

    // held count
    always_comb begin
        count_next = count_reg;
        if (ctrl.op == CELL_INS) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.op == CELL_DEL) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_acc) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            removed_reg <= do_del ? 32'(rd_word) : 32'd0;
            status_reg  <= status;
            cnt_out_reg <= 5'(count_next);
            empty_reg   <= (count_next == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, empty_reg, cnt_out_reg, removed_reg};
    assign m_tuser  = status_reg;

endmodule

// ----- hdl/ilu_checker.sv -----
`include "assert_macros.svh"

module ilu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ilu_pkg::*;

    // a stalled result holds
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // empty flag agrees with the count
    `ASSERT_CLK(a_empty, aclk, aresetn, m_tvalid |-> (m_tdata[37] == (m_tdata[36:32] == 5'd0)), "empty flag disagrees with count")

    // a failed request returns no word
    `ASSERT_CLK(a_fail_zero, aclk, aresetn, m_tvalid && m_tuser != ST_OK |-> m_tdata[31:0] == 32'd0, "failed request returned a word")

    // reset drops the result
    `ASSERT_CLK_NR(a_reset, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind indexed_ordered_list_unit ilu_checker u_ilu_checker (.*);

// ----- tb/indexed_ordered_list_unit_tb.sv -----
`timescale 1ns / 100ps

module indexed_ordered_list_unit_tb;
    import ilu_pkg::*;

    localparam int LIST_CAPACITY = 16;
    localparam int IDLE_LIMIT    = 1000;
    localparam int TOTAL_ITEMS   = 1250;
    localparam int DRAIN_CYCLES  = 8;

    // kinds left unused by the block, both answered with out of range
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0] removed;
        logic [1:0]  status;
        logic [4:0]  count;
        logic        empty;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // position[4:0], value[36:5], pad
    logic [2:0]  s_tuser = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // removed_value[31:0], count_now[36:32], is_empty[37], pad
    logic [1:0]  m_tuser;        // status[1:0]

    // predictor state: list contents front first, and results still owed
    logic [31:0]  list_words[$];
    list_result_t pending_results[$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    int  status_tally[4] = '{default: 0};
    int  times_full = 0;
    int  times_emptied = 0;
    bit  no_gaps = 1'b0;
    int  ready_hold = 0;

    indexed_ordered_list_unit #(
        .CAPACITY   (LIST_CAPACITY),
        .WORD_WIDTH (32)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // apply one request to the list copy and work out its result
    function automatic list_result_t apply_list_op(logic [2:0] kind, logic [4:0] pos,
                                                   logic [31:0] val);
        list_result_t res;
        int           cnt;
        cnt = list_words.size();
        res.removed = '0;
        res.status  = ST_OK;
        case (kind)
            KIND_ADD_FRONT, KIND_ADD_REAR, KIND_ADD_AT: begin
                // position range is tested ahead of the full test
                if (kind == KIND_ADD_AT && (pos == 0 || pos > cnt + 1))
                    res.status = ST_RANGE;
                else if (cnt >= LIST_CAPACITY)
                    res.status = ST_FULL;
                else if (kind == KIND_ADD_FRONT)
                    list_words.push_front(val);
                else if (kind == KIND_ADD_REAR)
                    list_words.push_back(val);
                else
                    list_words.insert(pos - 1, val);
                if (res.status == ST_OK && list_words.size() == LIST_CAPACITY)
                    times_full++;
            end
            KIND_DEL_FRONT, KIND_DEL_REAR: begin
                if (cnt == 0)
                    res.status = ST_UNDER;
                else if (kind == KIND_DEL_FRONT)
                    res.removed = list_words.pop_front();
                else
                    res.removed = list_words.pop_back();
            end
            KIND_DEL_AT: begin
                if (pos == 0 || pos > cnt) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = list_words[pos - 1];
                    list_words.delete(pos - 1);
                end
            end
            default: res.status = ST_RANGE;
        endcase
        if (cnt != 0 && list_words.size() == 0)
            times_emptied++;
        res.count = 5'(list_words.size());
        res.empty = (list_words.size() == 0);
        status_tally[res.status]++;
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        else if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at result %0d, %s: expected %h, got %h",
                     results_seen, what, want_v, got_v);
    endtask

    // present one item, wait for the handshake, then record its expected result
    task automatic send_item(input logic [2:0] kind, input logic [4:0] pos,
                             input logic [31:0] val);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            gap = 0;
        else if (r < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, val, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_list_op(kind, pos, val));
        items_sent++;
    endtask

    // result side stalls: short runs mostly, a few long; while no_gaps is set, none after the running hold ends
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(0, 99);
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_gaps) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_hold <= (r < 90) ? $urandom_range(0, 3) : $urandom_range(10, 50);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 32'h0, m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.removed)
                    note_mismatch("removed_value", want.removed, m_tdata[31:0]);
                if (m_tuser !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[36:32] !== want.count)
                    note_mismatch("count_now", 32'(want.count), 32'(m_tdata[36:32]));
                if (m_tdata[37] !== want.empty)
                    note_mismatch("is_empty", 32'(want.empty), 32'(m_tdata[37]));
            end
        end
    end

    // watchdog: cycles in which neither side moved an item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // requests on an empty list, and the two unused kinds
    task automatic test_empty_list_requests();
        send_item(KIND_DEL_FRONT, 5'd0, 32'h0);
        send_item(KIND_DEL_REAR, 5'd31, 32'hFFFF_FFFF);
        send_item(KIND_DEL_AT, 5'd0, 32'h0);
        send_item(KIND_DEL_AT, 5'd1, 32'h1234_5678);
        send_item(KIND_ADD_AT, 5'd0, 32'hDEAD_BEEF);
        send_item(KIND_ADD_AT, 5'd2, 32'hDEAD_BEEF);
        send_item(KIND_SPARE_6, 5'd1, 32'h0000_0001);
        send_item(KIND_SPARE_7, 5'd31, 32'h8000_0000);
    endtask

    // every kind of add, with extreme words, until the list is full
    task automatic test_fill_to_capacity();
        logic [2:0] kind;
        send_item(KIND_ADD_AT, 5'd1, 32'h0000_0000);
        send_item(KIND_ADD_FRONT, 5'd0, 32'hFFFF_FFFF);
        send_item(KIND_ADD_REAR, 5'd31, 32'h5555_5555);
        send_item(KIND_ADD_AT, 5'd4, 32'hAAAA_AAAA);
        send_item(KIND_ADD_AT, 5'd2, 32'h8000_0001);
        while (list_words.size() < LIST_CAPACITY) begin
            kind = 3'($urandom_range(KIND_ADD_FRONT, KIND_ADD_AT));
            send_item(kind, 5'($urandom_range(1, list_words.size() + 1)), rand_word());
        end
    endtask

    // requests against a full list, then removals at the ends and in the middle
    task automatic test_full_list_requests();
        send_item(KIND_ADD_FRONT, 5'd0, 32'h1111_1111);
        send_item(KIND_ADD_AT, 5'd18, 32'h2222_2222);
        send_item(KIND_ADD_AT, 5'd17, 32'h3333_3333);
        send_item(KIND_DEL_AT, 5'd17, 32'h0);
        send_item(KIND_DEL_AT, 5'd16, 32'h0);
        send_item(KIND_DEL_AT, 5'd1, 32'h0);
        send_item(KIND_DEL_REAR, 5'd0, 32'h0);
        send_item(KIND_DEL_AT, 5'd7, 32'h0);
    endtask

    // bursts that lean toward growing or shrinking, so full and empty both recur
    task automatic test_random_traffic(input int n_items);
        int         left;
        int         burst;
        int         add_pct;
        int         cnt;
        logic [2:0] kind;
        logic [4:0] pos;
        left = n_items;
        while (left > 0) begin
            burst = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       add_pct = 25;
                1:       add_pct = 50;
                default: add_pct = 80;
            endcase
            no_gaps = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < burst && left > 0; i++) begin
                cnt = list_words.size();
                if ($urandom_range(0, 99) < 12) begin
                    // noise: any kind, any position
                    kind = 3'($urandom_range(0, 7));
                    pos  = 5'($urandom_range(0, 31));
                end else if ($urandom_range(0, 99) < add_pct) begin
                    kind = 3'($urandom_range(KIND_ADD_FRONT, KIND_ADD_AT));
                    pos  = 5'($urandom_range(1, cnt + 1));
                end else begin
                    kind = 3'($urandom_range(KIND_DEL_FRONT, KIND_DEL_AT));
                    pos  = (cnt == 0) ? 5'd0 : 5'($urandom_range(1, cnt));
                end
                send_item(kind, pos, rand_word());
                left--;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_list_requests();
        test_fill_to_capacity();
        test_full_list_requests();
        test_random_traffic(TOTAL_ITEMS - items_sent);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests checked: %0d ok, %0d underflow, %0d out of range, %0d full",
                 items_sent, status_tally[ST_OK], status_tally[ST_UNDER],
                 status_tally[ST_RANGE], status_tally[ST_FULL]);
        $display("list filled to capacity %0d times and emptied %0d times",
                 times_full, times_emptied);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
